### design/u8vd_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
package u8vd_pkg;

  localparam int CpW = 21;
  localparam logic [CpW-1:0] ERROR_VALUE_RESET = 21'd65533;

  // Open-sequence state carried from one byte to the next.
  typedef struct packed {
    logic [7:0]     lead;
    logic [CpW-1:0] partial;
    logic [1:0]     seen;
    logic [1:0]     needed;   // 0: no sequence open
  } dec_state_t;

  // A run of results caused by one byte: cnt-1 error results, then the
  // final result described by cp/err/eot.
  typedef struct packed {
    logic [2:0]     cnt;
    logic [CpW-1:0] cp;
    logic           err;
    logic           eot;
  } run_t;

endpackage

### design/u8vd_decode.sv
// Next-state and result-run logic for one input byte.
module u8vd_decode (
  input  logic [7:0]                 data_byte,
  input  u8vd_pkg::dec_state_t       state,
  input  logic [u8vd_pkg::CpW-1:0]   error_value,
  output u8vd_pkg::dec_state_t       state_nxt,
  output u8vd_pkg::run_t             run
);

  // lead-byte handling
  logic                       ld_res;
  logic [u8vd_pkg::CpW-1:0]   ld_cp;
  logic                       ld_err;
  logic                       ld_eot;
  u8vd_pkg::dec_state_t       ld_state;

  logic [7:0] lo;
  logic [7:0] hi;
  logic       cont_ok;
  logic [1:0] seen_inc;
  logic [2:0] err_cnt;

  always_comb begin
    ld_res   = 1'b1;
    ld_cp    = error_value;
    ld_err   = 1'b1;
    ld_eot   = 1'b0;
    ld_state = '0;
    if (data_byte == 8'h00) begin
      ld_cp  = '0;
      ld_err = 1'b0;
      ld_eot = 1'b1;
    end else if (data_byte < 8'h80) begin
      ld_cp  = {13'd0, data_byte};
      ld_err = 1'b0;
    end else if (data_byte inside {[8'h80:8'hC1], [8'hF5:8'hFF]}) begin
      ld_cp  = error_value;
    end else begin
      ld_res        = 1'b0;
      ld_state.lead = data_byte;
      if (data_byte < 8'hE0) begin
        ld_state.needed  = 2'd1;
        ld_state.partial = {16'd0, data_byte[4:0]};
      end else if (data_byte < 8'hF0) begin
        ld_state.needed  = 2'd2;
        ld_state.partial = {17'd0, data_byte[3:0]};
      end else begin
        ld_state.needed  = 2'd3;
        ld_state.partial = {18'd0, data_byte[2:0]};
      end
    end
  end

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    // first continuation bounds exclude overlongs, surrogates, > U+10FFFF
    if (state.seen == 2'd0) begin
      case (state.lead)
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
    cont_ok  = (data_byte >= lo) && (data_byte <= hi);
    seen_inc = 2'(state.seen + 2'd1);
    err_cnt  = (state.seen >= 2'd2) ? 3'd3 : 3'(3'd1 + {1'b0, state.seen});
  end

  always_comb begin
    state_nxt = state;
    run       = '0;
    if (state.needed == 2'd0) begin
      state_nxt = ld_res ? state : ld_state;
      run.cnt   = {2'd0, ld_res};
      run.cp    = ld_cp;
      run.err   = ld_err;
      run.eot   = ld_eot;
    end else if (cont_ok) begin
      state_nxt.partial = {state.partial[14:0], data_byte[5:0]};
      state_nxt.seen    = seen_inc;
      if (seen_inc >= state.needed) begin
        state_nxt.needed = 2'd0;
        state_nxt.seen   = 2'd0;
        run.cnt          = 3'd1;
        run.cp           = {state.partial[14:0], data_byte[5:0]};
      end
    end else begin
      // errors for the lead and each accepted continuation, then re-lead
      state_nxt = ld_res ? '0 : ld_state;
      run.cnt   = 3'(err_cnt + {2'd0, ld_res});
      run.cp    = ld_res ? ld_cp : error_value;
      run.err   = ld_res ? ld_err : 1'b1;
      run.eot   = ld_res & ld_eot;
    end
  end

endmodule

### design/utf8_validating_decoder.sv
// Top level: strict UTF-8 byte-stream decoder with error replay.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_data_byte[7:0]
//   out_     output     out_valid/out_stall  out_code_point[20:0], out_is_error,
//                                            out_end_of_text, out_last_of_run
//   cfg_     input      cfg_valid/cfg_ready  cfg_data[20:0] (error_value)
//
// A byte is decoded in the cycle it is accepted; its results (0 to 4) leave
// one per cycle, while out_stall is low, from the active run register. Its
// run is registered there, or in a second run buffer that lets a byte be
// taken while a result waits. One byte per cycle is sustained while each
// byte gives at most one result and out_stall is low.
// Reset is synchronous: no sequence open, error_value back to U+FFFD.
module utf8_validating_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic        out_is_error,
  output logic        out_end_of_text,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data
);

  u8vd_pkg::dec_state_t     state_r, state_nxt;
  u8vd_pkg::run_t           run;
  u8vd_pkg::run_t           act_r, act_nxt;
  u8vd_pkg::run_t           pend_r, pend_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  logic [u8vd_pkg::CpW-1:0] error_value_r;
  u8vd_pkg::dec_state_t     dec_state;

  logic in_acc;
  logic act_done;

  u8vd_decode u_decode (
    .data_byte   (in_data_byte),
    .state       (state_r),
    .error_value (error_value_r),
    .state_nxt   (dec_state),
    .run         (run)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = pend_valid_r;
  assign in_acc    = in_valid && !pend_valid_r;
  // active run is empty after this edge
  assign act_done  = (act_r.cnt == 3'd0) || ((act_r.cnt == 3'd1) && !out_stall);

  assign out_valid       = (act_r.cnt != 3'd0);
  assign out_last_of_run = (act_r.cnt == 3'd1);
  assign out_code_point  = out_last_of_run ? act_r.cp : error_value_r;
  assign out_is_error    = out_last_of_run ? act_r.err : 1'b1;
  assign out_end_of_text = out_last_of_run & act_r.eot;

  always_comb begin
    state_nxt      = in_acc ? dec_state : state_r;
    act_nxt        = act_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (out_valid && !out_stall) begin
      act_nxt.cnt = 3'(act_r.cnt - 3'd1);
    end
    if (act_done) begin
      if (pend_valid_r) begin
        act_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end else if (in_acc && (run.cnt != 3'd0)) begin
        act_nxt = run;
      end
    end else if (in_acc && (run.cnt != 3'd0)) begin
      pend_nxt       = run;
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= '0;
      act_r         <= '0;
      pend_r        <= '0;
      pend_valid_r  <= 1'b0;
      error_value_r <= u8vd_pkg::ERROR_VALUE_RESET;
    end else begin
      state_r      <= state_nxt;
      act_r        <= act_nxt;
      pend_r       <= pend_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        error_value_r <= cfg_data;
      end
    end
  end

endmodule

### tb/utf8_validating_decoder_test.sv
// Testbench for the UTF-8 validating decoder: byte stimulus with a code point scoreboard.
module utf8_validating_decoder_test;

  localparam int STALL_LIMIT = 5000;  // cycles with no transfer before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES = 8;     // settle time after the last result
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 80;

  typedef struct {
    logic [u8vd_pkg::CpW-1:0] cp;
    logic                     err;
    logic                     eot;
    logic                     last;
  } cp_result_t;

  // Decoder mirror plus the queue of code points still owed by the block.
  class cp_board;
    cp_result_t               owed[$];
    cp_result_t               run[$];
    logic [u8vd_pkg::CpW-1:0] error_value;
    logic [7:0]               lead;
    logic [u8vd_pkg::CpW-1:0] partial;
    logic [1:0]               seen;
    logic [1:0]               needed;
    int                       mismatches;

    function new();
      error_value = u8vd_pkg::ERROR_VALUE_RESET;
      lead        = '0;
      partial     = '0;
      seen        = '0;
      needed      = '0;
      mismatches  = 0;
    endfunction

    function void set_error_value(logic [u8vd_pkg::CpW-1:0] v);
      error_value = v;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function bit clean();
      return mismatches == 0 && owed.size() == 0;
    endfunction

    function void emit(logic [u8vd_pkg::CpW-1:0] cp, logic err, logic eot);
      cp_result_t r;
      r.cp   = cp;
      r.err  = err;
      r.eot  = eot;
      r.last = 1'b0;
      run.push_back(r);
    endfunction

    function void take_lead(logic [7:0] b);
      if (b == 8'h00) begin
        emit('0, 1'b0, 1'b1);
      end else if (b < 8'h80) begin
        emit({13'd0, b}, 1'b0, 1'b0);
      end else if (b < 8'hC2 || b >= 8'hF5) begin
        emit(error_value, 1'b1, 1'b0);
      end else begin
        lead = b;
        seen = '0;
        if (b < 8'hE0) begin
          needed  = 2'd1;
          partial = {16'd0, b[4:0]};
        end else if (b < 8'hF0) begin
          needed  = 2'd2;
          partial = {17'd0, b[3:0]};
        end else begin
          needed  = 2'd3;
          partial = {18'd0, b[2:0]};
        end
      end
    endfunction

    // Accepted input item: work out the code points it produces.
    function void note_byte(logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      int         accepted;
      run.delete();
      if (needed == 0) begin
        take_lead(b);
      end else begin
        lo = 8'h80;
        hi = 8'hBF;
        // first continuation bounds rule out overlongs, surrogates, > U+10FFFF
        if (seen == 0) begin
          case (lead)
            8'hE0: lo = 8'hA0;
            8'hED: hi = 8'h9F;
            8'hF0: lo = 8'h90;
            8'hF4: hi = 8'h8F;
            default: ;
          endcase
        end
        if (b >= lo && b <= hi) begin
          partial = {partial[u8vd_pkg::CpW-7:0], b[5:0]};
          seen    = seen + 2'd1;
          if (seen >= needed) begin
            emit(partial, 1'b0, 1'b0);
            needed = '0;
            seen   = '0;
          end
        end else begin
          // error for the lead, one per accepted continuation, then rescan
          accepted = seen;
          needed   = '0;
          seen     = '0;
          emit(error_value, 1'b1, 1'b0);
          for (int k = 0; k < accepted && k < 2; k++) emit(error_value, 1'b1, 1'b0);
          take_lead(b);
        end
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) owed.push_back(run[i]);
    endfunction

    function void flag(string what, cp_result_t want, cp_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected cp=%h err=%b eot=%b last=%b, got cp=%h err=%b eot=%b last=%b",
                 what, want.cp, want.err, want.eot, want.last,
                 got.cp, got.err, got.eot, got.last);
    endfunction

    function void check_cp(cp_result_t got);
      cp_result_t want;
      if (owed.size() == 0) begin
        want = '{'0, 1'b0, 1'b0, 1'b0};
        flag("result with none owed", want, got);
        return;
      end
      want = owed.pop_front();
      if (got.cp !== want.cp || got.err !== want.err || got.eot !== want.eot ||
          got.last !== want.last)
        flag("code point mismatch", want, got);
    endfunction
  endclass

  logic           clk          = 1'b0;
  logic           rst_n        = 1'b0;
  logic           in_valid     = 1'b0;
  logic           in_stall;
  logic [7:0]     in_data_byte = 8'h00;
  logic           out_valid;
  logic           out_stall    = 1'b0;
  logic [20:0]    out_code_point;
  logic           out_is_error;
  logic           out_end_of_text;
  logic           out_last_of_run;
  logic           cfg_valid    = 1'b0;
  logic           cfg_ready;
  logic [20:0]    cfg_data     = '0;

  bit             tx_steady    = 1'b0;
  bit             rx_steady    = 1'b0;
  bit             rx_hold      = 1'b0;
  int             bytes_sent   = 0;
  cp_board        board        = new();

  utf8_validating_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_is_error    (out_is_error),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b);
    bytes_sent++;
  endtask

  // multibyte sequence; broken ones stop early and end on a random byte
  task automatic send_seq(input bit broken);
    int         len;
    int         good;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    len = $urandom_range(2, 4);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: lead = 8'hE0;
        1: lead = 8'hED;
        2: lead = 8'hF0;
        default: lead = 8'hF4;
      endcase
      len = (lead < 8'hF0) ? 3 : 4;
    end else if (len == 2) begin
      lead = 8'($urandom_range(8'hC2, 8'hDF));
    end else if (len == 3) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
    end else begin
      lead = 8'($urandom_range(8'hF0, 8'hF4));
    end
    lo = 8'h80;
    hi = 8'hBF;
    case (lead)
      8'hE0: lo = 8'hA0;
      8'hED: hi = 8'h9F;
      8'hF0: lo = 8'h90;
      8'hF4: hi = 8'h8F;
      default: ;
    endcase
    good = broken ? $urandom_range(0, len - 2) : len - 1;
    send_byte(lead);
    for (int i = 0; i < good; i++) begin
      send_byte(8'($urandom_range(lo, hi)));
      lo = 8'h80;
      hi = 8'hBF;
    end
    if (broken) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input int count);
    int stop_at;
    int r;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 25)      send_byte(8'($urandom_range(0, 8'h7F)));
      else if (r < 70) send_seq(1'b0);
      else if (r < 85) send_seq(1'b1);
      else             send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // sender pauses until every owed code point has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_error_value(input logic [20:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_error_value(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF,
            8'hC2, 8'h80,
            8'hE0, 8'h9F,                // overlong 3-byte
            8'hED, 8'hA0,                // surrogate
            8'hF4, 8'h8F, 8'hBF, 8'hBF,  // U+10FFFF
            8'hF0, 8'h8F,                // overlong 4-byte
            8'hF1, 8'h80, 8'h80, 8'h00,  // two accepted, then terminator: four results
            8'hE1, 8'h80, 8'hE2, 8'h82, 8'hAC};  // bad byte opens a new sequence
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  always @(posedge clk) begin
    cp_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.cp   = out_code_point;
      got.err  = out_is_error;
      got.eot  = out_end_of_text;
      got.last = out_last_of_run;
      board.check_cp(got);
    end
  end

  initial begin
    int n;
    forever begin
      if (rx_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        n = pick_gap(rx_steady);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("[utf8_validating_decoder] ERROR");
    $finish;
  end

  initial begin
    logic [20:0] ev[PHASES];
    ev[0] = 21'h1FFFFF;
    ev[1] = 21'h000000;
    ev[2] = 21'($urandom_range(0, 21'h10FFFF));
    ev[3] = 21'h10FFFF;
    ev[4] = 21'($urandom);
    ev[5] = u8vd_pkg::ERROR_VALUE_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      write_error_value(ev[p]);
      tx_steady = (p == 2) || (p == 4);
      rx_steady = (p == 4);
      // receiver holds off while the sender keeps pushing
      if (p == 2) rx_hold = 1'b1;
      if (p == 0) send_directed();
      send_text(PHASE_ITEMS);
    end
    drain();
    if (board.clean())
      $display("[utf8_validating_decoder] OK");
    else
      $display("[utf8_validating_decoder] ERROR");
    $finish;
  end

endmodule
